// ===== rtl/mcss_pkg.sv =====
`timescale 1ns / 1ps

package mcss_pkg;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_LOAD  = 2'd0;
    localparam mode_t MODE_START = 2'd1;
    localparam mode_t MODE_STEP  = 2'd2;

    // word index of the configuration registers
    localparam logic REG_NUM_STATES = 1'b0;

endpackage

// ===== rtl/mcss_table.sv =====
`timescale 1ns / 1ps

module mcss_table #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 17
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mcss_walk.sv =====
`timescale 1ns / 1ps

module mcss_walk #(
    parameter int MAX_STATES     = 64,
    parameter int PROB_FRAC_BITS = 16,
    parameter int STATE_W        = $clog2(MAX_STATES),
    parameter int CFG_W          = $clog2(MAX_STATES + 1),
    parameter int PROB_W         = PROB_FRAC_BITS + 1,
    parameter int AW             = $clog2(MAX_STATES * MAX_STATES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  mcss_pkg::mode_t     mode,
    input  logic [STATE_W-1:0]  row_index,
    input  logic [STATE_W-1:0]  column_index,
    input  logic [PROB_W-1:0]   probability,
    input  logic [STATE_W-1:0]  start_state,
    input  logic [PROB_FRAC_BITS-1:0] draw,
    input  logic [CFG_W-1:0]    num_states,
    output logic                tbl_we,
    output logic [AW-1:0]       tbl_waddr,
    output logic [PROB_W-1:0]   tbl_wdata,
    output logic                tbl_re,
    output logic [AW-1:0]       tbl_raddr,
    input  logic [PROB_W-1:0]   tbl_rdata,
    output logic                emit_valid,
    output logic [STATE_W-1:0]  emit_state,
    input  logic                emit_take
);

    import mcss_pkg::*;

    localparam int SUM_W = PROB_W + STATE_W;
    localparam logic [PROB_W-1:0] PROB_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    function automatic logic [AW-1:0] tbl_addr(input logic [STATE_W-1:0] r,
                                               input logic [STATE_W-1:0] c);
        return AW'(r) * AW'(MAX_STATES) + AW'(c);
    endfunction

    logic [1:0]                state_reg,    state_next;
    logic [STATE_W-1:0]        cur_reg,      cur_next;
    logic [PROB_FRAC_BITS-1:0] draw_reg,     draw_next;
    logic [STATE_W-1:0]        rd_col_reg,   rd_col_next;
    logic [STATE_W-1:0]        data_col_reg, data_col_next;
    logic [SUM_W-1:0]          sum_reg,      sum_next;
    logic [STATE_W-1:0]        res_reg,      res_next;

    logic [CFG_W-1:0]   n_use;
    logic [STATE_W-1:0] last_col;
    logic [SUM_W-1:0]   acc;
    logic               hit;
    logic               accept;

    always_comb
    begin
        if (num_states == '0)
        begin
            n_use = CFG_W'(1);
        end
        else if (num_states > CFG_W'(MAX_STATES))
        begin
            n_use = CFG_W'(MAX_STATES);
        end
        else
        begin
            n_use = num_states;
        end
    end

    assign last_col   = STATE_W'(n_use - CFG_W'(1));
    assign acc        = sum_reg + SUM_W'(tbl_rdata);
    assign hit        = acc > SUM_W'(draw_reg);
    assign item_stall = state_reg != S_IDLE;
    assign accept     = item_valid && !item_stall;
    assign emit_valid = state_reg == S_EMIT;
    assign emit_state = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        draw_next     = draw_reg;
        rd_col_next   = rd_col_reg;
        data_col_next = data_col_reg;
        sum_next      = sum_reg;
        res_next      = res_reg;
        tbl_we        = 1'b0;
        tbl_waddr     = tbl_addr(row_index, column_index);
        tbl_wdata     = (probability > PROB_ONE) ? PROB_ONE : probability;
        tbl_re        = 1'b0;
        tbl_raddr     = tbl_addr(cur_reg, rd_col_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_LOAD:
                        begin
                            tbl_we = (CFG_W'(row_index) < CFG_W'(MAX_STATES))
                                  && (CFG_W'(column_index) < CFG_W'(MAX_STATES));
                        end
                        MODE_START:
                        begin
                            cur_next = (CFG_W'(start_state) >= n_use) ? last_col
                                                                      : start_state;
                            res_next   = cur_next;
                            state_next = S_EMIT;
                        end
                        MODE_STEP:
                        begin
                            tbl_re        = 1'b1;
                            tbl_raddr     = tbl_addr(cur_reg, '0);
                            draw_next     = draw;
                            rd_col_next   = STATE_W'(1);
                            data_col_next = '0;
                            sum_next      = '0;
                            state_next    = S_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                tbl_re        = 1'b1;
                rd_col_next   = rd_col_reg + STATE_W'(1);
                data_col_next = rd_col_reg;
                sum_next      = acc;
                if (hit || data_col_reg == last_col)
                begin
                    res_next   = hit ? data_col_reg : last_col;
                    cur_next   = res_next;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        draw_reg     <= draw_next;
        rd_col_reg   <= rd_col_next;
        data_col_reg <= data_col_next;
        sum_reg      <= sum_next;
        res_reg      <= res_next;
    end

endmodule

// ===== rtl/markov_chain_step_sampler.sv =====
`timescale 1ns / 1ps

// Markov chain sampler over a loaded transition table. A load item (mode 0)
// writes one Q1.16 probability, saturated to 1.0, into the table; the block
// stays ready for the next item. A start item (mode 1) sets the current
// state, clamped below num_states, and returns it; the block is ready again
// once the result has moved into the output register. A step item (mode 2)
// walks the current row one table entry per cycle through the single read
// port of the table memory, from column 0, summing probabilities, and
// returns the first column whose running sum exceeds the draw (num_states-1
// if none does). The result sits in an output register, so the next item is
// taken while the last result waits. Entries must be loaded before a step
// reads them. The user must write num_states over the APB port at address 0
// only while the block is idle; the block itself does not enforce this.
module markov_chain_step_sampler #(
    parameter int MAX_STATES     = 64,
    parameter int PROB_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  mcss_pkg::mode_t               mode,
    input  logic [$clog2(MAX_STATES)-1:0] row_index,
    input  logic [$clog2(MAX_STATES)-1:0] column_index,
    input  logic [PROB_FRAC_BITS:0]       probability,
    input  logic [$clog2(MAX_STATES)-1:0] start_state,
    input  logic [PROB_FRAC_BITS-1:0]     draw,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [$clog2(MAX_STATES)-1:0] chain_state
);

    import mcss_pkg::*;

    localparam int STATE_W = $clog2(MAX_STATES);
    localparam int CFG_W   = $clog2(MAX_STATES + 1);
    localparam int PROB_W  = PROB_FRAC_BITS + 1;
    localparam int DEPTH   = MAX_STATES * MAX_STATES;
    localparam int AW      = $clog2(DEPTH);

    logic [CFG_W-1:0]   num_states_reg;
    logic               result_valid_reg;
    logic [STATE_W-1:0] chain_state_reg;

    logic               tbl_we;
    logic [AW-1:0]      tbl_waddr;
    logic [PROB_W-1:0]  tbl_wdata;
    logic               tbl_re;
    logic [AW-1:0]      tbl_raddr;
    logic [PROB_W-1:0]  tbl_rdata;
    logic               emit_valid;
    logic [STATE_W-1:0] emit_state;
    logic               emit_take;
    logic               cfg_wr;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == REG_NUM_STATES);
    assign prdata    = (paddr[2] == REG_NUM_STATES) ? 32'(num_states_reg) : '0;
    assign emit_take = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg <= CFG_W'(MAX_STATES);
        end
        else if (cfg_wr)
        begin
            num_states_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit_take)
        begin
            result_valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_take && emit_valid)
        begin
            chain_state_reg <= emit_state;
        end
    end

    assign result_valid = result_valid_reg;
    assign chain_state  = chain_state_reg;

    mcss_walk #(
        .MAX_STATES     (MAX_STATES),
        .PROB_FRAC_BITS (PROB_FRAC_BITS),
        .STATE_W        (STATE_W),
        .CFG_W          (CFG_W),
        .PROB_W         (PROB_W),
        .AW             (AW)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .row_index    (row_index),
        .column_index (column_index),
        .probability  (probability),
        .start_state  (start_state),
        .draw         (draw),
        .num_states   (num_states_reg),
        .tbl_we       (tbl_we),
        .tbl_waddr    (tbl_waddr),
        .tbl_wdata    (tbl_wdata),
        .tbl_re       (tbl_re),
        .tbl_raddr    (tbl_raddr),
        .tbl_rdata    (tbl_rdata),
        .emit_valid   (emit_valid),
        .emit_state   (emit_state),
        .emit_take    (emit_take)
    );

    mcss_table #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (PROB_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

endmodule
